// ===== rtl/aral_pkg.sv =====
// shared types and constants for the address-range section lookup
// used by aral_parse, aral_obuf and dwarf_aranges_address_lookup_core
package aral_pkg;

	// parser phase, one-hot
	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_TUPLE  = 3'b010,
		PH_DONE   = 3'b100
	} phase_t;

	typedef enum logic [2:0] {
		ST_FOUND     = 3'd0,
		ST_NOT_FOUND = 3'd1,
		ST_FMT64     = 3'd2,
		ST_VERSION   = 3'd3,
		ST_ADDR_SIZE = 3'd4,
		ST_TRUNCATED = 3'd5
	} status_t;

	typedef struct packed {
		logic        valid;
		status_t     status;
		logic [31:0] unit_offset;
	} res_t;

	localparam logic [31:0] LEN_ESCAPE   = 32'hFFFF_FFFF;
	localparam logic [15:0] VERSION_OK   = 16'd2;
	localparam logic [7:0]  ADDR_SIZE_OK = 8'd8;

	// byte positions inside a 16-byte header or tuple
	localparam logic [3:0] POS_LEN_LAST  = 4'd3;
	localparam logic [3:0] POS_VER_LO    = 4'd4;
	localparam logic [3:0] POS_VER_HI    = 4'd5;
	localparam logic [3:0] POS_UNIT_LO   = 4'd6;
	localparam logic [3:0] POS_UNIT_HI   = 4'd9;
	localparam logic [3:0] POS_ADDR_SIZE = 4'd10;
	localparam logic [3:0] POS_LAST      = 4'd15;

endpackage

// ===== rtl/aral_parse.sv =====
// byte parser of the address-range section: header fields, tuples, range test
// depends on aral_pkg
module aral_parse (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                first_byte,
	input  logic                last_byte,
	input  logic [63:0]         query_address,
	output aral_pkg::res_t      res
);

	aral_pkg::phase_t phase_q;
	logic [3:0]       pos_q;
	logic [23:0]      len_q;
	logic [7:0]       ver_q;
	logic [31:0]      unit_q;
	logic [63:0]      begin_q;
	logic [55:0]      rlen_q;

	aral_pkg::phase_t cur_phase, nxt_phase;
	logic [3:0]       p, nxt_pos;
	logic             hit;
	aral_pkg::status_t hit_status;
	logic [63:0]      full_len, range_end;
	logic [3:0]       unit_idx;

	assign cur_phase = first_byte ? aral_pkg::PH_HEADER : phase_q;
	assign p         = first_byte ? 4'd0 : pos_q;
	assign full_len  = {data_byte, rlen_q};
	assign range_end = begin_q + full_len;
	assign unit_idx  = p - aral_pkg::POS_UNIT_LO;

	always_comb begin
		nxt_phase  = cur_phase;
		nxt_pos    = p;
		hit        = 1'b0;
		hit_status = aral_pkg::ST_NOT_FOUND;
		res        = '0;
		unique case (cur_phase)
			aral_pkg::PH_HEADER: begin
				nxt_pos = p + 4'd1;
				if (p == aral_pkg::POS_LEN_LAST && {data_byte, len_q} == aral_pkg::LEN_ESCAPE) begin
					hit        = 1'b1;
					hit_status = aral_pkg::ST_FMT64;
				end else if (p == aral_pkg::POS_VER_HI && {data_byte, ver_q} != aral_pkg::VERSION_OK) begin
					hit        = 1'b1;
					hit_status = aral_pkg::ST_VERSION;
				end else if (p == aral_pkg::POS_ADDR_SIZE && data_byte != aral_pkg::ADDR_SIZE_OK) begin
					hit        = 1'b1;
					hit_status = aral_pkg::ST_ADDR_SIZE;
				end else if (p == aral_pkg::POS_LAST) begin
					nxt_phase = aral_pkg::PH_TUPLE;
					nxt_pos   = 4'd0;
				end
			end
			aral_pkg::PH_TUPLE: begin
				nxt_pos = p + 4'd1;
				if (p == aral_pkg::POS_LAST) begin
					nxt_pos = 4'd0;
					if (begin_q <= query_address && query_address < range_end) begin
						hit        = 1'b1;
						hit_status = aral_pkg::ST_FOUND;
					end else if (begin_q == 64'd0 && full_len == 64'd0) begin
						// terminator tuple, another set may follow
						nxt_phase = aral_pkg::PH_HEADER;
					end
				end
			end
			aral_pkg::PH_DONE: begin
				nxt_pos = p;
			end
			default: begin
				nxt_pos = p;
			end
		endcase

		if (cur_phase != aral_pkg::PH_DONE) begin
			if (hit) begin
				res.valid  = 1'b1;
				res.status = hit_status;
				if (hit_status == aral_pkg::ST_FOUND)
					res.unit_offset = unit_q;
			end else if (last_byte) begin
				res.valid = 1'b1;
				if (nxt_phase == aral_pkg::PH_HEADER && nxt_pos == 4'd0)
					res.status = aral_pkg::ST_NOT_FOUND;
				else
					res.status = aral_pkg::ST_TRUNCATED;
			end
		end
		if (res.valid)
			nxt_phase = aral_pkg::PH_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= aral_pkg::PH_HEADER;
			pos_q   <= 4'd0;
		end else if (step) begin
			phase_q <= nxt_phase;
			pos_q   <= nxt_pos;
		end
	end

	// field bytes; every byte is rewritten before it is read
	always_ff @(posedge clk) begin
		if (step) begin
			if (cur_phase == aral_pkg::PH_HEADER) begin
				if (p < aral_pkg::POS_LEN_LAST)
					len_q[8*p[1:0] +: 8] <= data_byte;
				if (p == aral_pkg::POS_VER_LO)
					ver_q <= data_byte;
				if (p >= aral_pkg::POS_UNIT_LO && p <= aral_pkg::POS_UNIT_HI)
					unit_q[8*unit_idx[1:0] +: 8] <= data_byte;
			end else if (cur_phase == aral_pkg::PH_TUPLE) begin
				if (!p[3])
					begin_q[8*p[2:0] +: 8] <= data_byte;
				else if (p != aral_pkg::POS_LAST)
					rlen_q[8*p[2:0] +: 8] <= data_byte;
			end
		end
	end

`ifndef SYNTHESIS
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == aral_pkg::PH_DONE && !first_byte |-> !res.valid)
		else $error("result produced after scan finished");
	a_res_ends_scan: assert property (@(posedge clk) disable iff (!arst_n)
		step && res.valid |=> phase_q == aral_pkg::PH_DONE)
		else $error("scan not closed after result");
	a_unit_zero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.status != aral_pkg::ST_FOUND |-> res.unit_offset == 32'd0)
		else $error("unit offset nonzero on a miss");
`endif

endmodule

// ===== rtl/aral_obuf.sv =====
// result register of the lookup, holds a result until the receiver takes it
// depends on aral_pkg
module aral_obuf (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           load,
	input  logic           take,
	input  aral_pkg::res_t res,
	output logic           out_valid,
	output aral_pkg::status_t out_status,
	output logic [31:0]    out_unit
);

	logic valid_q;
	aral_pkg::status_t status_q;
	logic [31:0] unit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= res.valid;
		end else if (take) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load && res.valid) begin
			status_q <= res.status;
			unit_q   <= res.unit_offset;
		end
	end

	assign out_valid  = valid_q;
	assign out_status = status_q;
	assign out_unit   = unit_q;

endmodule

// ===== rtl/dwarf_aranges_address_lookup_core.sv =====
// top level of the address-range section lookup
// depends on aral_pkg, aral_parse and aral_obuf
//
// usage: load the 64-bit query into the register through cfg_we/cfg_wdata while
// the block is idle, then stream the section one byte per beat on the s_ side.
// s_tuser marks the first byte of a section and restarts the parser; s_tlast
// marks the final byte. each scan gives one result beat on the m_ side:
// m_tuser carries the status, m_tdata the unit offset of the matching set.
// bytes after a scan's result are dropped until the next first-byte mark.
// throughput: one byte per cycle while the result register is empty or taken;
// a byte sits in the input register, then the header decode, range add and
// compare run combinationally into the result register, which offers the
// result beat; a stall on the m_ side can hold the byte between the two.
// when a result waits and m_tready is low the result register holds; the input
// register keeps one byte and s_tready drops until the result is taken.
// reset clears the parser to expect a set header, empties both registers and
// sets the query to zero.
module dwarf_aranges_address_lookup_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [63:0] cfg_wdata,   // query_address
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,     // data_byte
	input  logic        s_tuser,     // first_byte
	input  logic        s_tlast,     // last_byte
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // unit_offset
	output logic [2:0]  m_tuser      // status
);

	logic [63:0] query_q;
	logic        v_s1;
	logic [7:0]  byte_s1;
	logic        first_s1;
	logic        last_s1;
	logic        adv;
	aral_pkg::res_t    res;
	aral_pkg::status_t out_status;

	assign adv      = v_s1 && (!m_tvalid || m_tready);
	assign s_tready = !v_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			query_q <= 64'd0;
			v_s1    <= 1'b0;
		end else begin
			if (cfg_we)
				query_q <= cfg_wdata;
			if (s_tready)
				v_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			byte_s1  <= s_tdata;
			first_s1 <= s_tuser;
			last_s1  <= s_tlast;
		end
	end

	aral_parse u_parse (
		.clk          (clk),
		.arst_n       (arst_n),
		.step         (adv),
		.data_byte    (byte_s1),
		.first_byte   (first_s1),
		.last_byte    (last_s1),
		.query_address(query_q),
		.res          (res)
	);

	aral_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (adv),
		.take      (m_tready),
		.res       (res),
		.out_valid (m_tvalid),
		.out_status(out_status),
		.out_unit  (m_tdata)
	);

	assign m_tuser = out_status;

endmodule

// ===== bench/tb_dwarf_aranges_address_lookup_core.sv =====
// self-checking bench for dwarf_aranges_address_lookup_core: streams address-range
// sections one byte per beat, predicts each scan result and checks the result beats
// depends on aral_pkg and the core rtl only
module tb_dwarf_aranges_address_lookup_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TARGET_BEATS = 1350;
	localparam int SCANS_PER_QUERY = 3;
	localparam int CALM_AFTER   = 1000;
	localparam int HOLD_AFTER   = 500;
	localparam int HOLD_CYCLES  = 400;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int NO_LAST      = -1;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       last;
	} section_beat_t;

	typedef struct {
		aral_pkg::status_t status;
		logic [31:0]       unit_offset;
	} lookup_result_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [63:0] cfg_wdata = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;     // data_byte
	logic        s_tuser = 1'b0;   // first_byte
	logic        s_tlast = 1'b0;   // last_byte
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [31:0] m_tdata;          // unit_offset
	logic [2:0]  m_tuser;          // status

	dwarf_aranges_address_lookup_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	section_beat_t  beats_to_send [$];
	logic [7:0]     sec_bytes [$];
	lookup_result_t results_due [$];

	// scan state mirrored from the block
	logic [63:0]      query = '0;
	aral_pkg::phase_t sc_phase = aral_pkg::PH_HEADER;
	logic [3:0]  sc_pos = '0;
	logic [31:0] sc_len = '0;
	logic [15:0] sc_ver = '0;
	logic [31:0] sc_unit = '0;
	logic [63:0] sc_begin = '0;
	logic [63:0] sc_size = '0;

	int  errors = 0;
	int  live_beats = 0;
	int  ignored_beats = 0;
	int  results_checked = 0;
	int  query_writes = 0;
	int  status_count [6];
	int  cycle_count = 0;
	int  src_gap = 0;
	int  snk_gap = 0;
	int  rx_hold_left = 0;
	bit  rx_hold_done = 1'b0;
	bit  src_idle_on = 1'b1;
	bit  snk_idle_on = 1'b1;
	bit  calm = 1'b0;

	initial begin
		forever #6 clk = ~clk;
	end

	// one section byte through the scan; hit is set on the byte that decides the scan
	task automatic scan_byte(input logic [7:0] b, input logic first, input logic last,
			output logic hit, output aral_pkg::status_t st, output logic [31:0] uo,
			output logic ignored);
		logic [3:0]  p;
		logic [63:0] range_end;
		hit = 1'b0;
		st = aral_pkg::ST_NOT_FOUND;
		uo = '0;
		ignored = 1'b0;
		if (first) begin
			sc_phase = aral_pkg::PH_HEADER;
			sc_pos = '0;
		end
		if (sc_phase == aral_pkg::PH_DONE) begin
			ignored = 1'b1;
			return;
		end
		p = sc_pos;
		if (sc_phase == aral_pkg::PH_HEADER) begin
			if (p <= aral_pkg::POS_LEN_LAST) begin
				sc_len[8*p +: 8] = b;
				if (p == aral_pkg::POS_LEN_LAST && sc_len == aral_pkg::LEN_ESCAPE) begin
					hit = 1'b1;
					st = aral_pkg::ST_FMT64;
				end
			end else if (p <= aral_pkg::POS_VER_HI) begin
				sc_ver[8*(p - aral_pkg::POS_VER_LO) +: 8] = b;
				if (p == aral_pkg::POS_VER_HI && sc_ver != aral_pkg::VERSION_OK) begin
					hit = 1'b1;
					st = aral_pkg::ST_VERSION;
				end
			end else if (p <= aral_pkg::POS_UNIT_HI) begin
				sc_unit[8*(p - aral_pkg::POS_UNIT_LO) +: 8] = b;
			end else if (p == aral_pkg::POS_ADDR_SIZE && b != aral_pkg::ADDR_SIZE_OK) begin
				hit = 1'b1;
				st = aral_pkg::ST_ADDR_SIZE;
			end
			if (!hit) begin
				if (p == aral_pkg::POS_LAST) begin
					sc_phase = aral_pkg::PH_TUPLE;
					sc_pos = '0;
				end else begin
					sc_pos = p + 4'd1;
				end
			end
		end else begin
			if (p < 4'd8)
				sc_begin[8*p +: 8] = b;
			else
				sc_size[8*(p - 4'd8) +: 8] = b;
			if (p == aral_pkg::POS_LAST) begin
				range_end = sc_begin + sc_size;
				if (sc_begin <= query && query < range_end) begin
					hit = 1'b1;
					st = aral_pkg::ST_FOUND;
					uo = sc_unit;
				end else begin
					sc_pos = '0;
					// all-zero tuple closes the set
					if (sc_begin == '0 && sc_size == '0)
						sc_phase = aral_pkg::PH_HEADER;
				end
			end else begin
				sc_pos = p + 4'd1;
			end
		end
		// a decision on the last beat wins over the end of the section
		if (!hit && last) begin
			hit = 1'b1;
			if (sc_phase == aral_pkg::PH_HEADER && sc_pos == '0)
				st = aral_pkg::ST_NOT_FOUND;
			else
				st = aral_pkg::ST_TRUNCATED;
		end
		if (hit)
			sc_phase = aral_pkg::PH_DONE;
	endtask

	// sender: offers queued beats, predicts on every accepted beat
	always @(posedge clk) begin
		section_beat_t     nb;
		lookup_result_t    lr;
		logic              hit, ign;
		aral_pkg::status_t st;
		logic [31:0]       uo;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else begin
			if (s_tvalid && s_tready) begin
				scan_byte(s_tdata, s_tuser, s_tlast, hit, st, uo, ign);
				if (ign)
					ignored_beats++;
				else
					live_beats++;
				if (hit) begin
					lr.status = st;
					lr.unit_offset = uo;
					results_due.push_back(lr);
					status_count[st]++;
				end
			end
			if (!s_tvalid || s_tready) begin
				if (src_gap > 0) begin
					src_gap--;
					s_tvalid <= 1'b0;
				end else if (beats_to_send.size() != 0) begin
					nb = beats_to_send.pop_front();
					s_tvalid <= 1'b1;
					s_tdata <= nb.data;
					s_tuser <= nb.first;
					s_tlast <= nb.last;
					if (src_idle_on && !calm && $urandom_range(0, 7) == 0)
						src_gap = $urandom_range(1, 16);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result beat against the oldest predicted one
	always @(posedge clk) begin
		lookup_result_t want;
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (results_due.size() == 0) begin
					$error("result beat with no scan decided: status %0d unit_offset %h",
						m_tuser, m_tdata);
					errors++;
				end else begin
					want = results_due.pop_front();
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						errors++;
					end
					if (m_tdata !== want.unit_offset) begin
						$error("unit_offset: expected %h, got %h", want.unit_offset, m_tdata);
						errors++;
					end
					results_checked++;
				end
			end
			if (rx_hold_left != 0) begin
				m_tready <= 1'b0;
			end else if (snk_gap > 0) begin
				snk_gap--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
				if (snk_idle_on && !calm && $urandom_range(0, 5) == 0)
					snk_gap = $urandom_range(1, 16);
			end
		end
	end

	// one long receiver stall so the result register and input register both fill
	always @(posedge clk) begin
		if (!arst_n) begin
			rx_hold_left <= 0;
		end else if (rx_hold_left != 0) begin
			rx_hold_left <= rx_hold_left - 1;
		end else if (!rx_hold_done && live_beats + ignored_beats >= HOLD_AFTER) begin
			rx_hold_left <= HOLD_CYCLES;
			rx_hold_done <= 1'b1;
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
				results_due.size());
			$display("tb_dwarf_aranges_address_lookup_core NOT OK");
			$finish;
		end
	end

	task automatic set_query(input logic [63:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		query = v;
		query_writes++;
	endtask

	// idle: every beat taken, every result seen, plus the block's pipeline depth
	task automatic drain();
		@(negedge clk);
		while (beats_to_send.size() != 0 || s_tvalid || results_due.size() != 0)
			@(negedge clk);
		repeat (6) @(posedge clk);
	endtask

	task automatic add_val(input logic [63:0] v, input int n);
		for (int i = 0; i < n; i++)
			sec_bytes.push_back(v[8*i +: 8]);
	endtask

	task automatic add_header(input logic [31:0] len, input logic [15:0] ver,
			input logic [31:0] unit, input logic [7:0] asz);
		add_val(len, 4);
		add_val(ver, 2);
		add_val(unit, 4);
		add_val(asz, 1);
		add_val($urandom, 1);   // segment
		add_val($urandom, 4);   // padding
	endtask

	task automatic add_tuple(input logic [63:0] range_begin, input logic [63:0] range_len);
		add_val(range_begin, 8);
		add_val(range_len, 8);
	endtask

	task automatic flush_scan(input bit first_mark, input int last_at);
		section_beat_t bt;
		foreach (sec_bytes[i]) begin
			bt.data = sec_bytes[i];
			bt.first = first_mark && (i == 0);
			bt.last = (i == last_at);
			beats_to_send.push_back(bt);
		end
		sec_bytes.delete();
	endtask

	task automatic add_random_tuple();
		logic [63:0] off, span;
		off = 64'($urandom_range(0, 255));
		if (off > query)
			off = query;
		span = 64'($urandom_range(1, 64));
		case ($urandom_range(0, 5))
			0: add_tuple(query - off, off + span);      // holds the query
			1: add_tuple(query - span, span);           // ends right at the query
			2: add_tuple(query + 64'd1, {$urandom, $urandom});
			3: add_tuple(query, '0);
			4: add_tuple({$urandom, $urandom}, {$urandom, $urandom});
			default: add_tuple({$urandom, $urandom}, span);
		endcase
	endtask

	function automatic logic [31:0] random_len();
		case ($urandom_range(0, 3))
			0: return 32'h0;
			1: return 32'hFFFF_FFFE;
			default: return $urandom;
		endcase
	endfunction

	task automatic directed_scans();
		// no first mark after reset: parsing starts as if a section had begun
		add_val(aral_pkg::LEN_ESCAPE, 4);
		flush_scan(1'b0, NO_LAST);
		// dropped after a result, last mark too
		add_val(64'h00FF_A5, 3);
		flush_scan(1'b0, 2);
		// version bytes swapped, decided on the beat marked last
		add_val(32'h2C, 4);
		add_val(16'h0200, 2);
		flush_scan(1'b1, 5);
		add_header(32'h1C, aral_pkg::VERSION_OK, 32'h0, 8'd4);
		flush_scan(1'b1, NO_LAST);
		// abandoned mid-header by the next first mark
		add_header(32'h2C, aral_pkg::VERSION_OK, 32'hDEAD_BEEF, aral_pkg::ADDR_SIZE_OK);
		sec_bytes = sec_bytes[0:6];
		flush_scan(1'b1, NO_LAST);
		// near misses before the match, match on the beat marked last
		add_header(32'h0, aral_pkg::VERSION_OK, 32'hFFFF_FFFF, aral_pkg::ADDR_SIZE_OK);
		add_tuple('1, '1);
		add_tuple(query, 64'h0);
		add_tuple(query - 64'h10, 64'h10);
		add_tuple(query, 64'h1);
		flush_scan(1'b1, sec_bytes.size() - 1);
		add_header(32'hFFFF_FFFE, aral_pkg::VERSION_OK, 32'h1234_5678, aral_pkg::ADDR_SIZE_OK);
		add_tuple(query + 64'h1, 64'hFFFF);
		add_tuple('0, '0);
		flush_scan(1'b1, sec_bytes.size() - 1);
		// match sits in the second set
		add_header(32'h2C, aral_pkg::VERSION_OK, 32'h0000_0100, aral_pkg::ADDR_SIZE_OK);
		add_tuple(64'h0, 64'h1000);
		add_tuple('0, '0);
		add_header(32'h2C, aral_pkg::VERSION_OK, 32'h8000_0001, aral_pkg::ADDR_SIZE_OK);
		add_tuple(query - 64'h5, 64'h6);
		add_tuple('0, '0);
		flush_scan(1'b1, sec_bytes.size() - 1);
		// ends in the padding
		add_header(32'h2C, aral_pkg::VERSION_OK, 32'h55AA_55AA, aral_pkg::ADDR_SIZE_OK);
		sec_bytes = sec_bytes[0:12];
		flush_scan(1'b1, 12);
		// ends after a tuple that is not the terminator
		add_header(32'h2C, aral_pkg::VERSION_OK, 32'h0000_0007, aral_pkg::ADDR_SIZE_OK);
		add_tuple(64'h0, 64'h1);
		flush_scan(1'b1, sec_bytes.size() - 1);
		add_val(64'h0, 1);
		flush_scan(1'b1, 0);
	endtask

	task automatic random_scan();
		section_beat_t bt;
		int            kind, cut, last_at;
		bit            first_mark;
		logic [15:0]   ver;
		logic [7:0]    asz;
		kind = $urandom_range(0, 99);
		first_mark = ($urandom_range(0, 19) != 0);
		if (kind >= 94) begin
			// noise with stray marks
			repeat ($urandom_range(1, 24)) begin
				bt.data = $urandom;
				bt.first = ($urandom_range(0, 7) == 0);
				bt.last = ($urandom_range(0, 7) == 0);
				beats_to_send.push_back(bt);
			end
			return;
		end
		ver = aral_pkg::VERSION_OK;
		asz = aral_pkg::ADDR_SIZE_OK;
		if (kind >= 68 && kind < 76) begin
			ver = $urandom;
			if (ver == aral_pkg::VERSION_OK)
				ver = 16'h0200;
		end else if (kind >= 76 && kind < 84) begin
			asz = $urandom;
			if (asz == aral_pkg::ADDR_SIZE_OK)
				asz = 8'd4;
		end
		add_header((kind >= 60 && kind < 68) ? aral_pkg::LEN_ESCAPE : random_len(), ver,
			$urandom, asz);
		repeat ($urandom_range(0, 3)) add_random_tuple();
		add_tuple('0, '0);
		if (kind < 60 && $urandom_range(0, 4) == 0) begin
			add_header(random_len(), aral_pkg::VERSION_OK, $urandom, aral_pkg::ADDR_SIZE_OK);
			repeat ($urandom_range(0, 3)) add_random_tuple();
			add_tuple('0, '0);
		end
		last_at = sec_bytes.size() - 1;
		if (kind >= 84) begin
			// cut short: truncated, or left open for the next first mark
			cut = $urandom_range(1, sec_bytes.size() - 1);
			sec_bytes = sec_bytes[0:cut-1];
			last_at = ($urandom_range(0, 1) == 0) ? cut - 1 : NO_LAST;
		end else if (kind < 60) begin
			case ($urandom_range(0, 9))
				0: begin
					sec_bytes = sec_bytes[0:sec_bytes.size()-17];
					last_at = sec_bytes.size() - 1;
				end
				1: last_at = NO_LAST;
				default: ;
			endcase
		end
		flush_scan(first_mark, last_at);
	endtask

	initial begin
		int          round;
		logic [63:0] q;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		set_query(64'h0000_0000_0040_1000);
		directed_scans();
		drain();
		round = 0;
		while (live_beats + ignored_beats < TARGET_BEATS) begin
			case (round % 6)
				0: q = '0;
				1: q = '1;
				2: q = {$urandom, $urandom};
				3: q = 64'($urandom_range(0, 4095));
				4: q = {32'hFFFF_FFFF, $urandom};
				default: q = {$urandom, $urandom};
			endcase
			set_query(q);
			src_idle_on = ($urandom_range(0, 3) != 0);
			snk_idle_on = ($urandom_range(0, 3) != 0);
			calm = (live_beats + ignored_beats >= CALM_AFTER);
			repeat (SCANS_PER_QUERY) random_scan();
			drain();
			round++;
		end
		repeat (8) @(posedge clk);
		$display("scanned %0d section beats (%0d dropped after a result) over %0d query values",
			live_beats, ignored_beats, query_writes);
		$display("results: found %0d, not found %0d, 64-bit %0d, version %0d, size %0d, truncated %0d",
			status_count[0], status_count[1], status_count[2], status_count[3],
			status_count[4], status_count[5]);
		if (errors == 0)
			$display("tb_dwarf_aranges_address_lookup_core OK");
		else
			$display("tb_dwarf_aranges_address_lookup_core NOT OK");
		$finish;
	end

endmodule

// ===== sim.f =====
rtl/aral_pkg.sv
rtl/aral_parse.sv
rtl/aral_obuf.sv
rtl/dwarf_aranges_address_lookup_core.sv
bench/tb_dwarf_aranges_address_lookup_core.sv
